// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the token scanner.
// Self-contained: no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed: next-cycle implication");

`endif

// ===== rtl/bltok_pkg.sv =====
// Shared types, codes and tables for the B-language token scanner.
// No dependencies.
package bltok_pkg;

  localparam int MAX_TEXT_LEN = 31;
  localparam int TC_W         = $clog2(MAX_TEXT_LEN + 1);
  localparam int KIND_W       = 6;
  localparam int LEN_W        = 5;
  localparam int KW_COUNT     = 9;
  localparam int KW_MAX       = 6;
  localparam int KW_IDX_W     = $clog2(KW_MAX);
  localparam int KW_BITS      = 8 * KW_MAX;
  localparam int RQ_DEPTH     = 4;
  localparam int RQ_PTR_W     = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W     = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } src_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [15:0]       token_value;
    logic [LEN_W-1:0]  text_length;
    logic [15:0]       line_number;
    logic              last_result;
  } tok_word_t;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUM, MODE_CHAR, MODE_CHAR_ESC, MODE_STR, MODE_STR_ESC,
    MODE_PLUS, MODE_MINUS, MODE_BANG, MODE_LT, MODE_GT, MODE_EQ, MODE_EQEQ, MODE_EQLT,
    MODE_EQGT
  } mode_t;

  // Token kinds
  localparam logic [KIND_W-1:0] TK_END     = 6'd0;
  localparam logic [KIND_W-1:0] TK_INT     = 6'd1;
  localparam logic [KIND_W-1:0] TK_IDENT   = 6'd2;
  localparam logic [KIND_W-1:0] TK_STRING  = 6'd3;
  localparam logic [KIND_W-1:0] TK_AUTO    = 6'd4;
  localparam logic [KIND_W-1:0] TK_CHAR    = 6'd13;
  localparam logic [KIND_W-1:0] TK_INC     = 6'd14;
  localparam logic [KIND_W-1:0] TK_DEC     = 6'd15;
  localparam logic [KIND_W-1:0] TK_NE      = 6'd16;
  localparam logic [KIND_W-1:0] TK_LE      = 6'd17;
  localparam logic [KIND_W-1:0] TK_SHL     = 6'd18;
  localparam logic [KIND_W-1:0] TK_GE      = 6'd19;
  localparam logic [KIND_W-1:0] TK_SHR     = 6'd20;
  localparam logic [KIND_W-1:0] TK_AS_OR   = 6'd21;
  localparam logic [KIND_W-1:0] TK_AS_AND  = 6'd22;
  localparam logic [KIND_W-1:0] TK_AS_EQ   = 6'd23;
  localparam logic [KIND_W-1:0] TK_AS_EQEQ = 6'd24;
  localparam logic [KIND_W-1:0] TK_AS_LT   = 6'd25;
  localparam logic [KIND_W-1:0] TK_AS_LE   = 6'd26;
  localparam logic [KIND_W-1:0] TK_AS_SHL  = 6'd27;
  localparam logic [KIND_W-1:0] TK_AS_GT   = 6'd28;
  localparam logic [KIND_W-1:0] TK_AS_GE   = 6'd29;
  localparam logic [KIND_W-1:0] TK_AS_SHR  = 6'd30;
  localparam logic [KIND_W-1:0] TK_AS_SUB  = 6'd31;
  localparam logic [KIND_W-1:0] TK_AS_ADD  = 6'd32;
  localparam logic [KIND_W-1:0] TK_AS_MOD  = 6'd33;
  localparam logic [KIND_W-1:0] TK_AS_MUL  = 6'd34;
  localparam logic [KIND_W-1:0] TK_AS_DIV  = 6'd35;

  // Source bytes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword text, first byte in the top byte, unused bytes zero.
  function automatic logic [KW_BITS-1:0] kw_word(input int k);
    logic [KW_BITS-1:0] w;
    case (k)
      0:       w = 48'h6175746F0000;  // auto
      1:       w = 48'h657874726E00;  // extrn
      2:       w = 48'h696600000000;  // if
      3:       w = 48'h656C73650000;  // else
      4:       w = 48'h7768696C6500;  // while
      5:       w = 48'h72657475726E;  // return
      6:       w = 48'h676F746F0000;  // goto
      7:       w = 48'h737769746368;  // switch
      8:       w = 48'h636173650000;  // case
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [TC_W-1:0] kw_len(input int k);
    logic [TC_W-1:0] n;
    case (k)
      0, 3, 6, 8: n = TC_W'(4);
      1, 4:       n = TC_W'(5);
      2:          n = TC_W'(2);
      5, 7:       n = TC_W'(6);
      default:    n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/bltok_rq.sv =====
// Result queue of the token scanner: takes up to two words a cycle, gives one.
// Depends on bltok_pkg.
module bltok_rq (
  input  logic                 clk,
  input  logic                 rst,
  input  bltok_pkg::tok_word_t wr0,
  input  bltok_pkg::tok_word_t wr1,
  input  logic [1:0]           wr_count,
  output logic                 room,
  output bltok_pkg::tok_word_t rd_data,
  output logic                 rd_valid,
  input  logic                 rd_ready
);
  import bltok_pkg::*;

  tok_word_t             mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wp;
  logic [RQ_PTR_W-1:0]   rp;
  logic [RQ_CNT_W-1:0]   count;
  logic                  pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  // Two free entries are needed, as one item can leave two tokens.
  assign room     = (count <= RQ_CNT_W'(RQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + RQ_PTR_W'(wr_count);
      rp    <= rp + RQ_PTR_W'(pop);
      count <= count + RQ_CNT_W'(wr_count) - RQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wp] <= wr0;
    end
    if (wr_count == 2'd2) begin
      mem[wp + RQ_PTR_W'(1)] <= wr1;
    end
  end

endmodule

// ===== rtl/bltok_core.sv =====
// Scanner state and one-pass step logic: one source word in, up to two tokens out.
// Depends on bltok_pkg.
module bltok_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  bltok_pkg::src_word_t item,
  output bltok_pkg::tok_word_t res0,
  output bltok_pkg::tok_word_t res1,
  output logic [1:0]           res_count
);
  import bltok_pkg::*;

  mode_t                 mode;
  mode_t                 mode_next;
  mode_t                 start_mode;
  logic [15:0]           line_count;
  logic [15:0]           line_count_next;
  logic [15:0]           acc;
  logic [15:0]           acc_next;
  logic                  octal;
  logic                  octal_next;
  logic [TC_W-1:0]       text_count;
  logic [TC_W-1:0]       text_count_next;
  logic [7:0]            prefix [KW_MAX];
  logic                  prefix_we;
  logic [KW_IDX_W-1:0]   prefix_idx;

  logic [7:0]            c;
  logic                  eoi;
  logic                  c_alpha;
  logic                  c_digit;
  logic                  c_space;
  logic                  start_single;
  logic                  rescan;
  logic [3:0]            dval;
  logic [15:0]           acc_oct;
  logic [15:0]           acc_dec;
  logic [KIND_W-1:0]     kw_kind;
  logic                  kw_hit;
  logic [KW_BITS-1:0]    kw_w;
  tok_word_t             flush_tok;
  tok_word_t             own_tok;
  logic                  flush_v;
  logic                  own_v;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b) inside
      CH_ZERO, CH_LO_E: r = 8'h00;
      CH_LPAREN:        r = CH_LBRACE;
      CH_RPAREN:        r = CH_RBRACE;
      CH_LO_T:          r = CH_TAB;
      CH_LO_N:          r = CH_NL;
      CH_LO_R:          r = CH_CR;
      CH_LO_A:          r = CH_BEL;
      default:          r = b;
    endcase
    return r;
  endfunction

  assign c       = item.character;
  assign eoi     = item.end_of_input;
  assign c_alpha = (c == CH_USCORE) || (c >= CH_LO_A && c <= CH_LO_Z) ||
                   (c >= CH_UP_A && c <= CH_UP_Z);
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  // Digit bytes sit at 0x30, so the low nibble is the digit value
  assign dval    = c[3:0];
  assign acc_oct = {acc[12:0], 3'b000} + 16'(dval);
  assign acc_dec = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + 16'(dval);

  // Mode a fresh byte opens when scanned from idle.
  always_comb begin
    start_mode = MODE_IDLE;
    if (c_alpha) begin
      start_mode = MODE_IDENT;
    end else if (c_digit) begin
      start_mode = MODE_NUM;
    end else begin
      case (c)
        CH_QUOTE:  start_mode = MODE_CHAR;
        CH_DQUOTE: start_mode = MODE_STR;
        CH_PLUS:   start_mode = MODE_PLUS;
        CH_MINUS:  start_mode = MODE_MINUS;
        CH_BANG:   start_mode = MODE_BANG;
        CH_LT:     start_mode = MODE_LT;
        CH_GT:     start_mode = MODE_GT;
        CH_EQ:     start_mode = MODE_EQ;
        default:   start_mode = MODE_IDLE;
      endcase
    end
  end

  assign start_single = (start_mode == MODE_IDLE) && !c_space;

  // Keyword lookup over the stored first bytes of the identifier.
  always_comb begin
    kw_kind = TK_IDENT;
    kw_hit  = 1'b0;
    kw_w    = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      kw_w   = kw_word(k);
      kw_hit = (text_count == kw_len(k));
      for (int i = 0; i < KW_MAX; i++) begin
        if (TC_W'(i) < kw_len(k) && prefix[i] != kw_w[KW_BITS-1-8*i -: 8]) begin
          kw_hit = 1'b0;
        end
      end
      if (kw_hit) begin
        kw_kind = TK_AUTO + KIND_W'(k);
      end
    end
  end

  // Next state
  always_comb begin
    rescan    = 1'b0;
    mode_next = mode;
    if (eoi) begin
      mode_next = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_IDLE:     rescan = 1'b1;
        MODE_IDENT:    rescan = !(c_alpha || c_digit);
        MODE_NUM:      rescan = !c_digit;
        MODE_CHAR: begin
          if (c == CH_QUOTE) begin
            mode_next = MODE_IDLE;
          end else if (c == CH_STAR) begin
            mode_next = MODE_CHAR_ESC;
          end
        end
        MODE_CHAR_ESC: mode_next = MODE_CHAR;
        MODE_STR: begin
          if (c == CH_DQUOTE) begin
            mode_next = MODE_IDLE;
          end else if (c == CH_STAR) begin
            mode_next = MODE_STR_ESC;
          end
        end
        MODE_STR_ESC:  mode_next = MODE_STR;
        MODE_PLUS: begin
          if (c == CH_PLUS) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_MINUS: begin
          if (c == CH_MINUS) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_BANG: begin
          if (c == CH_EQ) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_LT: begin
          if (c == CH_EQ || c == CH_LT) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_GT: begin
          if (c == CH_EQ || c == CH_GT) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_EQ: begin
          case (c) inside
            CH_BAR, CH_AMP, CH_MINUS, CH_PLUS, CH_PCT, CH_STAR, CH_SLASH:
                     mode_next = MODE_IDLE;
            CH_EQ:   mode_next = MODE_EQEQ;
            CH_LT:   mode_next = MODE_EQLT;
            CH_GT:   mode_next = MODE_EQGT;
            default: rescan = 1'b1;
          endcase
        end
        MODE_EQEQ: begin
          if (c == CH_EQ) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_EQLT: begin
          if (c == CH_EQ || c == CH_LT) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        MODE_EQGT: begin
          if (c == CH_EQ || c == CH_GT) mode_next = MODE_IDLE; else rescan = 1'b1;
        end
        default:       rescan = 1'b1;
      endcase
      if (rescan) begin
        mode_next = start_mode;
      end
    end
  end

  // Outputs: tokens and datapath updates
  always_comb begin
    acc_next        = acc;
    octal_next      = octal;
    text_count_next = text_count;
    line_count_next = line_count;
    prefix_we       = 1'b0;
    prefix_idx      = text_count[KW_IDX_W-1:0];
    flush_tok       = '0;
    own_tok         = '0;
    flush_tok.line_number = line_count;
    own_tok.line_number   = line_count;
    own_v           = 1'b0;

    // Token left pending by the current mode.
    unique case (mode) inside
      MODE_IDLE: ;
      MODE_IDENT: begin
        flush_tok.token_kind  = kw_kind;
        flush_tok.text_length = LEN_W'(text_count);
      end
      MODE_NUM: begin
        flush_tok.token_kind  = TK_INT;
        flush_tok.token_value = acc;
        flush_tok.text_length = LEN_W'(text_count);
      end
      MODE_CHAR, MODE_CHAR_ESC: begin
        flush_tok.token_kind  = TK_INT;
        flush_tok.token_value = acc;
      end
      MODE_STR, MODE_STR_ESC: flush_tok.token_kind = TK_STRING;
      MODE_PLUS: begin
        flush_tok.token_kind  = TK_CHAR;
        flush_tok.token_value = {8'h00, CH_PLUS};
      end
      MODE_MINUS: begin
        flush_tok.token_kind  = TK_CHAR;
        flush_tok.token_value = {8'h00, CH_MINUS};
      end
      MODE_BANG: begin
        flush_tok.token_kind  = TK_CHAR;
        flush_tok.token_value = {8'h00, CH_BANG};
      end
      MODE_LT: begin
        flush_tok.token_kind  = TK_CHAR;
        flush_tok.token_value = {8'h00, CH_LT};
      end
      MODE_GT: begin
        flush_tok.token_kind  = TK_CHAR;
        flush_tok.token_value = {8'h00, CH_GT};
      end
      MODE_EQ: begin
        flush_tok.token_kind  = TK_CHAR;
        flush_tok.token_value = {8'h00, CH_EQ};
      end
      MODE_EQEQ: flush_tok.token_kind = TK_AS_EQ;
      MODE_EQLT: flush_tok.token_kind = TK_AS_LT;
      MODE_EQGT: flush_tok.token_kind = TK_AS_GT;
      default: ;
    endcase
    flush_v = (eoi || rescan) && (mode != MODE_IDLE);

    if (eoi) begin
      own_v              = 1'b1;
      own_tok.token_kind = TK_END;
    end else if (rescan) begin
      acc_next        = '0;
      octal_next      = 1'b0;
      text_count_next = '0;
      if (c == CH_NL) begin
        line_count_next = line_count + 16'd1;
      end
      if (c_alpha) begin
        prefix_we       = 1'b1;
        prefix_idx      = '0;
        text_count_next = TC_W'(1);
      end
      if (c_digit) begin
        acc_next        = 16'(dval);
        octal_next      = (c == CH_ZERO);
        text_count_next = TC_W'(1);
      end
      if (start_single) begin
        own_v               = 1'b1;
        own_tok.token_kind  = TK_CHAR;
        own_tok.token_value = {8'h00, c};
      end
    end else begin
      unique case (mode)
        MODE_IDENT: begin
          prefix_we = (text_count < TC_W'(KW_MAX));
          if (text_count < TC_W'(MAX_TEXT_LEN)) begin
            text_count_next = text_count + TC_W'(1);
          end
        end
        MODE_NUM: begin
          acc_next = octal ? acc_oct : acc_dec;
          if (text_count < TC_W'(MAX_TEXT_LEN)) begin
            text_count_next = text_count + TC_W'(1);
          end
        end
        MODE_CHAR: begin
          if (c == CH_QUOTE) begin
            own_v               = 1'b1;
            own_tok.token_kind  = TK_INT;
            own_tok.token_value = acc;
          end else if (c != CH_STAR) begin
            acc_next = {acc[7:0], c};
          end
        end
        MODE_CHAR_ESC: acc_next = {acc[7:0], unescape(c)};
        MODE_STR: begin
          own_v              = (c == CH_DQUOTE);
          own_tok.token_kind = TK_STRING;
        end
        MODE_PLUS: begin
          own_v              = 1'b1;
          own_tok.token_kind = TK_INC;
        end
        MODE_MINUS: begin
          own_v              = 1'b1;
          own_tok.token_kind = TK_DEC;
        end
        MODE_BANG: begin
          own_v              = 1'b1;
          own_tok.token_kind = TK_NE;
        end
        MODE_LT: begin
          own_v              = 1'b1;
          own_tok.token_kind = (c == CH_EQ) ? TK_LE : TK_SHL;
        end
        MODE_GT: begin
          own_v              = 1'b1;
          own_tok.token_kind = (c == CH_EQ) ? TK_GE : TK_SHR;
        end
        MODE_EQ: begin
          own_v = 1'b1;
          case (c)
            CH_BAR:   own_tok.token_kind = TK_AS_OR;
            CH_AMP:   own_tok.token_kind = TK_AS_AND;
            CH_MINUS: own_tok.token_kind = TK_AS_SUB;
            CH_PLUS:  own_tok.token_kind = TK_AS_ADD;
            CH_PCT:   own_tok.token_kind = TK_AS_MOD;
            CH_STAR:  own_tok.token_kind = TK_AS_MUL;
            CH_SLASH: own_tok.token_kind = TK_AS_DIV;
            default:  own_v = 1'b0;  // two-byte prefix of a longer operator
          endcase
        end
        MODE_EQEQ: begin
          own_v              = 1'b1;
          own_tok.token_kind = TK_AS_EQEQ;
        end
        MODE_EQLT: begin
          own_v              = 1'b1;
          own_tok.token_kind = (c == CH_EQ) ? TK_AS_LE : TK_AS_SHL;
        end
        MODE_EQGT: begin
          own_v              = 1'b1;
          own_tok.token_kind = (c == CH_EQ) ? TK_AS_GE : TK_AS_SHR;
        end
        default: ;
      endcase
    end
  end

  // Pack the pending token first, then the one this word produced.
  always_comb begin
    res_count        = {1'b0, flush_v} + {1'b0, own_v};
    res0             = flush_v ? flush_tok : own_tok;
    res0.last_result = !(flush_v && own_v);
    res1             = own_tok;
    res1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      line_count <= 16'd1;
      acc        <= '0;
      octal      <= 1'b0;
      text_count <= '0;
    end else if (advance) begin
      mode       <= mode_next;
      line_count <= line_count_next;
      acc        <= acc_next;
      octal      <= octal_next;
      text_count <= text_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && prefix_we) begin
      prefix[prefix_idx] <= c;
    end
  end

endmodule

// ===== rtl/b_language_token_scanner.sv =====
// Top level of the B-language token scanner: input word register, step logic, result queue.
// Depends on bltok_pkg, bltok_core and bltok_rq.
//
//   channel | signals                       | word
//   --------+-------------------------------+----------------------------------------
//   source  | src_valid, src_ready, src_data | one byte or end-of-input mark
//   tokens  | tok_valid, tok_ready, tok_data | one token, last_result on the final one
//
// Flow: a word reaches the step logic in the cycle after it is taken; its tokens are written
// to the result queue and read on tok_data. One word a cycle is sustained while each word
// yields at most one token and tok_ready is high; a pair leaves the one-word port in turn.
// Reset: clears the scanner mode, the line count (to one), queue pointers and held_valid.
// Stalls: hold the registered word while the four-entry result queue has fewer than two free
// entries; a new word is taken in the same cycle as the held one moves on.
module b_language_token_scanner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  bltok_pkg::src_word_t src_data,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output bltok_pkg::tok_word_t tok_data
);
  import bltok_pkg::*;

  src_word_t  held_item;
  logic       held_valid;
  logic       room;
  logic       advance;
  tok_word_t  res0;
  tok_word_t  res1;
  logic [1:0] res_count;
  logic [1:0] push_count;

  // Advance the held word once the queue can take both tokens it might produce.
  assign advance    = held_valid && room;
  assign src_ready  = !held_valid || advance;
  assign push_count = advance ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (src_valid && src_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      held_item <= src_data;
    end
  end

  bltok_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (held_item),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  bltok_rq u_rq (
    .clk      (clk),
    .rst      (rst),
    .wr0      (res0),
    .wr1      (res1),
    .wr_count (push_count),
    .room     (room),
    .rd_data  (tok_data),
    .rd_valid (tok_valid),
    .rd_ready (tok_ready)
  );

endmodule

// ===== rtl/bltok_checker.sv =====
// Port-level checks on the token scanner, bound to its top level.
// Depends on bltok_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bltok_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 src_ready,
  input logic                 tok_valid,
  input logic                 tok_ready,
  input bltok_pkg::tok_word_t tok_data
);
  import bltok_pkg::*;

  logic tok_take;
  logic end_tok;

  assign tok_take = tok_valid && tok_ready;
  assign end_tok  = tok_valid && (tok_data.token_kind == TK_END);

  // Hold a stalled token word.
  `ASSERT_NEXT(a_tok_hold, clk, rst, tok_valid && !tok_ready, tok_valid && $stable(tok_data))

  // The second token of a word is queued with the first, so it follows at once.
  `ASSERT_NEXT(a_pair_follows, clk, rst, tok_take && !tok_data.last_result, tok_valid)

  // The end token always closes its word.
  `ASSERT_IMPLIES(a_end_last, clk, rst, end_tok, tok_data.last_result)

  // Nothing left in the queue straight after reset.
  `ASSERT_IMPLIES(a_reset_empty, clk, rst, $past(rst), !tok_valid)

  // The input register is free straight after reset.
  `ASSERT_IMPLIES(a_reset_ready, clk, rst, $past(rst), src_ready)

endmodule

bind b_language_token_scanner bltok_checker u_bltok_checker (
  .clk       (clk),
  .rst       (rst),
  .src_ready (src_ready),
  .tok_valid (tok_valid),
  .tok_ready (tok_ready),
  .tok_data  (tok_data)
);

// ===== dv/tb_b_language_token_scanner.sv =====
// Self-checking bench for the B-language token scanner: a directed byte stream, then random
// token-shaped text, checked token by token against a scanner model kept inside the bench.
// Depends on bltok_pkg and b_language_token_scanner.
module tb_b_language_token_scanner;
  import bltok_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  src_word_t src_data = '0;
  logic      tok_valid;
  logic      tok_ready = 1'b0;
  tok_word_t tok_data;

  b_language_token_scanner u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Source words waiting to be offered, and tokens the scanner model says are due.
  src_word_t src_pending[$];
  tok_word_t tok_due[$];
  int        total_words = 0;
  int        words_taken = 0;
  int        mismatches  = 0;

  // ---------------------------------------------------------------------------------------
  // Scanner model: its own copy of the mode, line count, accumulator and keyword prefix.
  // ---------------------------------------------------------------------------------------
  mode_t       scan_mode;
  logic [15:0] line_no;
  logic [15:0] accum;
  logic        octal;
  int unsigned txt_cnt;
  logic [7:0]  kw_pre[KW_MAX];
  tok_word_t   step_tok[2];
  int          step_n;

  string kw_list[9] = '{"auto", "extrn", "if", "else", "while", "return", "goto", "switch",
                        "case"};

  function automatic bit is_letter(logic [7:0] c);
    return c == CH_USCORE || (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Star escapes inside constants; anything not listed stands for itself.
  function automatic logic [7:0] star_escape(logic [7:0] c);
    case (c) inside
      CH_ZERO, CH_LO_E: return 8'h00;
      CH_LPAREN:        return CH_LBRACE;
      CH_RPAREN:        return CH_RBRACE;
      CH_LO_T:          return CH_TAB;
      CH_LO_N:          return CH_NL;
      CH_LO_R:          return CH_CR;
      CH_LO_A:          return CH_BEL;
      default:          return c;
    endcase
  endfunction

  // At most two tokens per word; stamp each with the line count as it stands now.
  function automatic void add_tok(logic [KIND_W-1:0] kind, logic [15:0] value,
                                  int unsigned len);
    if (step_n < 2) begin
      step_tok[step_n] = '{token_kind: kind, token_value: value, text_length: LEN_W'(len),
                           line_number: line_no, last_result: 1'b0};
      step_n++;
    end
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind();
    logic [KIND_W-1:0] kind;
    bit                hit;
    kind = TK_IDENT;
    for (int k = 0; k < 9; k++) begin
      if (kind == TK_IDENT && txt_cnt == kw_list[k].len()) begin
        hit = 1'b1;
        for (int i = 0; i < kw_list[k].len(); i++)
          if (kw_pre[i] != kw_list[k][i]) hit = 1'b0;
        if (hit) kind = TK_AUTO + KIND_W'(k);
      end
    end
    return kind;
  endfunction

  // Close whatever token is open and drop back to idle.
  function automatic void flush_token();
    case (scan_mode) inside
      MODE_IDENT:              add_tok(ident_kind(), 16'h0, txt_cnt);
      MODE_NUM:                add_tok(TK_INT, accum, txt_cnt);
      MODE_CHAR, MODE_CHAR_ESC: add_tok(TK_INT, accum, 0);
      MODE_STR, MODE_STR_ESC:  add_tok(TK_STRING, 16'h0, 0);
      MODE_PLUS:               add_tok(TK_CHAR, {8'h00, CH_PLUS}, 0);
      MODE_MINUS:              add_tok(TK_CHAR, {8'h00, CH_MINUS}, 0);
      MODE_BANG:               add_tok(TK_CHAR, {8'h00, CH_BANG}, 0);
      MODE_LT:                 add_tok(TK_CHAR, {8'h00, CH_LT}, 0);
      MODE_GT:                 add_tok(TK_CHAR, {8'h00, CH_GT}, 0);
      MODE_EQ:                 add_tok(TK_CHAR, {8'h00, CH_EQ}, 0);
      MODE_EQEQ:               add_tok(TK_AS_EQ, 16'h0, 0);
      MODE_EQLT:               add_tok(TK_AS_LT, 16'h0, 0);
      MODE_EQGT:               add_tok(TK_AS_GT, 16'h0, 0);
      default: ;
    endcase
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void finish_op(logic [KIND_W-1:0] kind);
    add_tok(kind, 16'h0, 0);
    scan_mode = MODE_IDLE;
  endfunction

  // Closing quote of a character constant: the last two bytes make the value.
  function automatic void finish_op_value();
    add_tok(TK_INT, accum, 0);
    scan_mode = MODE_IDLE;
  endfunction

  // Scan a byte from idle: skip blanks, open a token, or emit a single-char token.
  function automatic void start_token(logic [7:0] c);
    accum   = 16'h0;
    octal   = 1'b0;
    txt_cnt = 0;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      if (c == CH_NL) line_no = line_no + 16'd1;
    end else if (is_letter(c)) begin
      scan_mode = MODE_IDENT;
      kw_pre[0] = c;
      txt_cnt   = 1;
    end else if (is_num(c)) begin
      scan_mode = MODE_NUM;
      accum     = {8'h00, c - CH_ZERO};
      octal     = (c == CH_ZERO);
      txt_cnt   = 1;
    end else begin
      case (c)
        CH_QUOTE:  scan_mode = MODE_CHAR;
        CH_DQUOTE: scan_mode = MODE_STR;
        CH_PLUS:   scan_mode = MODE_PLUS;
        CH_MINUS:  scan_mode = MODE_MINUS;
        CH_BANG:   scan_mode = MODE_BANG;
        CH_LT:     scan_mode = MODE_LT;
        CH_GT:     scan_mode = MODE_GT;
        CH_EQ:     scan_mode = MODE_EQ;
        default:   add_tok(TK_CHAR, {8'h00, c}, 0);
      endcase
    end
  endfunction

  // Advance the model by one accepted source word and queue the tokens it yields.
  function automatic void predict_word(src_word_t w);
    logic [7:0] c;
    bit         rescan;
    c      = w.character;
    rescan = 1'b0;
    step_n = 0;
    if (w.end_of_input) begin
      flush_token();
      add_tok(TK_END, 16'h0, 0);
    end else begin
      case (scan_mode)
        MODE_IDLE: rescan = 1'b1;
        MODE_IDENT:
          if (is_letter(c) || is_num(c)) begin
            if (txt_cnt < KW_MAX) kw_pre[txt_cnt] = c;
            if (txt_cnt < MAX_TEXT_LEN) txt_cnt++;
          end else rescan = 1'b1;
        MODE_NUM:
          if (is_num(c)) begin
            // 8 and 9 after a leading 0 still go in with base 8
            accum = accum * (octal ? 16'd8 : 16'd10) + {8'h00, c - CH_ZERO};
            if (txt_cnt < MAX_TEXT_LEN) txt_cnt++;
          end else rescan = 1'b1;
        MODE_CHAR:
          if (c == CH_QUOTE) finish_op_value();
          else if (c == CH_STAR) scan_mode = MODE_CHAR_ESC;
          else accum = {accum[7:0], c};
        MODE_CHAR_ESC: begin
          accum     = {accum[7:0], star_escape(c)};
          scan_mode = MODE_CHAR;
        end
        MODE_STR:
          if (c == CH_DQUOTE) finish_op(TK_STRING);
          else if (c == CH_STAR) scan_mode = MODE_STR_ESC;
        MODE_STR_ESC: scan_mode = MODE_STR;
        MODE_PLUS:  if (c == CH_PLUS) finish_op(TK_INC); else rescan = 1'b1;
        MODE_MINUS: if (c == CH_MINUS) finish_op(TK_DEC); else rescan = 1'b1;
        MODE_BANG:  if (c == CH_EQ) finish_op(TK_NE); else rescan = 1'b1;
        MODE_LT:
          if (c == CH_EQ) finish_op(TK_LE);
          else if (c == CH_LT) finish_op(TK_SHL);
          else rescan = 1'b1;
        MODE_GT:
          if (c == CH_EQ) finish_op(TK_GE);
          else if (c == CH_GT) finish_op(TK_SHR);
          else rescan = 1'b1;
        MODE_EQ:
          case (c)
            CH_BAR:   finish_op(TK_AS_OR);
            CH_AMP:   finish_op(TK_AS_AND);
            CH_EQ:    scan_mode = MODE_EQEQ;
            CH_LT:    scan_mode = MODE_EQLT;
            CH_GT:    scan_mode = MODE_EQGT;
            CH_MINUS: finish_op(TK_AS_SUB);
            CH_PLUS:  finish_op(TK_AS_ADD);
            CH_PCT:   finish_op(TK_AS_MOD);
            CH_STAR:  finish_op(TK_AS_MUL);
            CH_SLASH: finish_op(TK_AS_DIV);
            default:  rescan = 1'b1;  // includes '=' then '!': the '!' is scanned afresh
          endcase
        MODE_EQEQ: if (c == CH_EQ) finish_op(TK_AS_EQEQ); else rescan = 1'b1;
        MODE_EQLT:
          if (c == CH_EQ) finish_op(TK_AS_LE);
          else if (c == CH_LT) finish_op(TK_AS_SHL);
          else rescan = 1'b1;
        MODE_EQGT:
          if (c == CH_EQ) finish_op(TK_AS_GE);
          else if (c == CH_GT) finish_op(TK_AS_SHR);
          else rescan = 1'b1;
        default: begin
          scan_mode = MODE_IDLE;
          rescan    = 1'b1;
        end
      endcase
      // A byte that cannot extend the open token closes it, then is scanned from idle
      if (rescan) begin
        flush_token();
        start_token(c);
      end
    end
    if (step_n > 0) step_tok[step_n-1].last_result = 1'b1;
    for (int i = 0; i < step_n; i++) tok_due.push_back(step_tok[i]);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus: source words built as token-shaped fragments.
  // ---------------------------------------------------------------------------------------
  string op_list[29] = '{"++", "--", "!=", "<=", "<<", ">=", ">>", "=|", "=&", "==", "===",
                         "=<", "=<=", "=<<", "=>", "=>=", "=>>", "=-", "=+", "=%", "=*", "=/",
                         "+", "-", "!", "<", ">", "=", "=!"};
  string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digits  = "0123456789";
  string escapes = "0e()tnra*'\"x";
  string blanks  = " \t\n";

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic put(logic [7:0] c);
    src_pending.push_back('{character: c, end_of_input: 1'b0});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // The byte beside an end mark is ignored, so let it take any value
  task automatic put_end();
    src_pending.push_back('{character: 8'($urandom), end_of_input: 1'b1});
  endtask

  // Body of a constant or string: plain bytes other than the quote and star, and star escapes.
  task automatic put_quoted(logic [7:0] quote, int max_len);
    logic [7:0] b;
    put(quote);
    repeat ($urandom_range(0, max_len)) begin
      if ($urandom_range(0, 2) == 0) begin
        put(CH_STAR);
        put($urandom_range(0, 3) == 0 ? 8'($urandom) : pick(escapes));
      end else begin
        do b = 8'($urandom); while (b == quote || b == CH_STAR);
        put(b);
      end
    end
    // Leave some unclosed so the following text lands inside them
    if ($urandom_range(0, 9) != 0) put(quote);
  endtask

  task automatic put_fragment();
    int unsigned sel;
    int          n;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      put(pick(letters));
      repeat (n - 1) put($urandom_range(0, 3) == 0 ? pick(digits) : pick(letters));
    end else if (sel < 25) begin
      put_text(kw_list[$urandom_range(0, 8)]);
      if ($urandom_range(0, 4) == 0) put(pick(letters));
    end else if (sel < 40) begin
      n = ($urandom_range(0, 15) == 0) ? 33 : $urandom_range(1, 6);
      if ($urandom_range(0, 2) == 0) begin
        put(CH_ZERO);
        n = n - 1;
      end
      repeat (n) put(pick(digits));
    end else if (sel < 50) begin
      put_quoted(CH_QUOTE, 4);
    end else if (sel < 58) begin
      put_quoted(CH_DQUOTE, 10);
    end else if (sel < 80) begin
      put_text(op_list[$urandom_range(0, 28)]);
    end else if (sel < 90) begin
      repeat ($urandom_range(1, 3)) put(pick(blanks));
    end else if (sel < 98) begin
      put(8'($urandom));
    end else begin
      put_end();
    end
    if ($urandom_range(0, 9) < 6) put(pick(blanks));
  endtask

  // ---------------------------------------------------------------------------------------
  // Idling policy shared by both sides: quiet in the tail and in every third window.
  // ---------------------------------------------------------------------------------------
  function automatic bit no_idling();
    return src_pending.size() < 150 || (words_taken / 128) % 3 == 2;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Source driver: take the word on a handshake, then offer the next one or idle.
  // ---------------------------------------------------------------------------------------
  int unsigned gap_left   = 0;
  bit          drain_hold = 1'b0;
  bit          drain_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      scan_mode  = MODE_IDLE;
      line_no    = 16'd1;
      accum      = 16'h0;
      octal      = 1'b0;
      txt_cnt    = 0;
    end else begin
      if (src_valid && src_ready) begin
        predict_word(src_data);
        words_taken++;
      end
      // Hold the word while it waits; otherwise the slot is free for the next one
      if (!src_valid || src_ready) begin
        // Once, pause until every due token has come out
        if (!drain_done && words_taken >= 800) begin
          drain_hold = 1'b1;
          drain_done = 1'b1;
        end
        if (drain_hold && tok_due.size() == 0) drain_hold = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (drain_hold || src_pending.size() == 0) begin
          src_valid <= 1'b0;
        end else begin
          src_data  <= src_pending.pop_front();
          src_valid <= 1'b1;
          if (!no_idling() && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 18);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Token monitor: check each accepted word against the oldest due token, then pick ready.
  // ---------------------------------------------------------------------------------------
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : tok_monitor
    tok_word_t due;
    if (rst) begin
      tok_ready <= 1'b0;
    end else begin
      if (tok_valid && tok_ready) begin
        if (tok_due.size() == 0) begin
          flag_mismatch($sformatf("token kind %0d with nothing due", tok_data.token_kind));
        end else begin
          due = tok_due.pop_front();
          if (tok_data.token_kind !== due.token_kind)
            flag_mismatch($sformatf("token_kind %0d, want %0d",
                                    tok_data.token_kind, due.token_kind));
          if (tok_data.token_value !== due.token_value)
            flag_mismatch($sformatf("token_value %0h, want %0h",
                                    tok_data.token_value, due.token_value));
          if (tok_data.text_length !== due.text_length)
            flag_mismatch($sformatf("text_length %0d, want %0d",
                                    tok_data.text_length, due.text_length));
          if (tok_data.line_number !== due.line_number)
            flag_mismatch($sformatf("line_number %0d, want %0d",
                                    tok_data.line_number, due.line_number));
          if (tok_data.last_result !== due.last_result)
            flag_mismatch($sformatf("last_result %0b, want %0b",
                                    tok_data.last_result, due.last_result));
        end
      end
      // Once, hold off for a long stretch so the result queue fills and the input stalls
      if (hold_left != 0) begin
        hold_left--;
        tok_ready <= 1'b0;
      end else if (!long_hold_done && words_taken >= 400) begin
        long_hold_done = 1'b1;
        hold_left      = 299;
        tok_ready <= 1'b0;
      end else if (!no_idling() && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(0, 17);
        tok_ready <= 1'b0;
      end else begin
        tok_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence: build the stream, release reset, wait for every word and token, then judge.
  // ---------------------------------------------------------------------------------------
  initial begin
    // Directed: extreme bytes and carriage return as single-char tokens
    put(8'h00);
    put(8'hFF);
    put(CH_CR);
    // '=' then '!' gives '=' alone, and the '!' joins the next '=' as !=
    put(CH_EQ);
    put(CH_BANG);
    put(CH_EQ);
    // Octal with 8 and 9 after the leading 0
    put_text("089 ");
    // Character constant: escaped brace as first byte, last two bytes kept
    put(CH_QUOTE);
    put(CH_STAR);
    put(CH_LPAREN);
    put_text("xy");
    put(CH_QUOTE);
    put(CH_NL);
    put_text("return");
    // End mark inside a string: string token, then end
    put(CH_DQUOTE);
    put_end();

    // Random text, closed by an end mark so nothing stays open
    while (src_pending.size() < 1275) put_fragment();
    put_end();
    total_words = src_pending.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (words_taken != total_words) @(posedge clk);
    while (tok_due.size() != 0) @(posedge clk);
    // Let any stray token surface before judging
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
